### src/dpt_pkg.sv
// Shared types and constants for the dosing pump timer bank.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

    // Command kinds as they arrive in tuser.
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_DOSE_TIME = 3'd1;
    localparam logic [2:0] KIND_DOSE_VOL  = 3'd2;
    localparam logic [2:0] KIND_STOP_ONE  = 3'd3;
    localparam logic [2:0] KIND_STOP_ALL  = 3'd4;

    localparam int          FLOW_REGS    = 4;
    localparam int          DRIVE_W      = 4;
    localparam logic [15:0] DEFAULT_FLOW = 16'd256;
    localparam logic [31:0] MIN_DOSE_MS  = 32'd100;
    localparam logic [9:0]  MS_PER_S     = 10'd1000;

    // Volume times 1000 needs 34 bits.
    localparam int DIV_W = 34;

    // Operation after classification; OP_NONE covers every ignored command.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_TIME,
        OP_VOLUME,
        OP_STOP_ONE,
        OP_STOP_ALL
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [2:0]  pump_id;
        logic [31:0] dose_time_ms;
        logic [23:0] dose_volume;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_LOAD
    } state_t;

endpackage

`default_nettype wire

### src/dpt_front.sv
// Front end: unpacks an incoming request and classifies it into an operation.
// Depends on dpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpt_front #(
    parameter int PUMP_COUNT = 4
) (
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,
    input  wire logic [2:0]   s_tuser,
    input  wire logic         q_full,
    output logic              push,
    output dpt_pkg::cmd_t     cmd
);

    logic [2:0]  pump_id;
    logic [31:0] dose_time_ms;
    logic [23:0] dose_volume;
    logic        id_ok;

    assign pump_id      = s_tdata[2:0];
    assign dose_time_ms = s_tdata[34:3];
    assign dose_volume  = s_tdata[58:35];
    assign id_ok        = {1'b0, pump_id} < 4'(PUMP_COUNT);

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    always_comb
    begin
        cmd.pump_id      = pump_id;
        cmd.dose_time_ms = dose_time_ms;
        cmd.dose_volume  = dose_volume;
        unique case (s_tuser)
            dpt_pkg::KIND_TICK:      cmd.op = dpt_pkg::OP_TICK;
            dpt_pkg::KIND_DOSE_TIME: cmd.op = id_ok ? dpt_pkg::OP_TIME : dpt_pkg::OP_NONE;
            dpt_pkg::KIND_DOSE_VOL:
                cmd.op = (id_ok && dose_volume != '0) ? dpt_pkg::OP_VOLUME : dpt_pkg::OP_NONE;
            dpt_pkg::KIND_STOP_ONE:  cmd.op = id_ok ? dpt_pkg::OP_STOP_ONE : dpt_pkg::OP_NONE;
            dpt_pkg::KIND_STOP_ALL:  cmd.op = dpt_pkg::OP_STOP_ALL;
            default:                 cmd.op = dpt_pkg::OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

### src/dpt_cmd_queue.sv
// Two-entry command queue between the front end and the executing back end.
// Depends on dpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpt_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire dpt_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               q_valid,
    output dpt_pkg::cmd_t      q_cmd
);

    dpt_pkg::cmd_t mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full    = count_reg == 2'd2;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### src/dpt_divider.sv
// Restoring divider, one quotient bit per cycle, for the volume-to-time conversion.
// Depends on dpt_pkg for the dividend width.
`timescale 1ns / 1ps
`default_nettype none

module dpt_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [dpt_pkg::DIV_W-1:0] dividend,
    input  wire logic [15:0]               divisor,
    output logic                           done,
    output logic [dpt_pkg::DIV_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(dpt_pkg::DIV_W + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [15:0]               rem_reg, rem_next;
    logic [15:0]               dsr_reg, dsr_next;
    logic [dpt_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [16:0]               trial;
    logic [16:0]               diff;
    logic                      ge;

    assign trial = {rem_reg, quo_reg[dpt_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(dpt_pkg::DIV_W);
            rem_next  = '0;
            dsr_next  = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so 16 bits hold it.
            rem_next = ge ? diff[15:0] : trial[15:0];
            quo_next = {quo_reg[dpt_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        quo_reg <= quo_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### src/dpt_back.sv
// Back end: executes queued commands on the pump timers and holds the result register.
// Depends on dpt_pkg and dpt_divider.
`timescale 1ns / 1ps
`default_nettype none

module dpt_back #(
    parameter int PUMP_COUNT = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [15:0]   flow_rate [dpt_pkg::FLOW_REGS],
    input  wire logic          q_valid,
    input  wire dpt_pkg::cmd_t q_cmd,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [39:0]        m_tdata
);

    dpt_pkg::state_t state_reg, state_next;

    logic [PUMP_COUNT-1:0] on_reg, on_next;
    logic [31:0]           rem_reg [PUMP_COUNT];
    logic [31:0]           rem_next [PUMP_COUNT];

    logic [2:0]  cur_id_reg;
    logic [23:0] cur_vol_reg;
    logic [15:0] flow_sel_reg;
    logic [31:0] loaded_reg, loaded_next;

    logic        out_valid_reg;
    logic [3:0]  drive_out_reg;
    logic        acc_out_reg;
    logic [31:0] loaded_out_reg;

    logic        out_free;
    logic        exec_en;
    dpt_pkg::op_t exec_op;
    logic [2:0]  exec_id;
    logic [31:0] exec_ms;
    logic        capture;
    logic [15:0] flow_sel;
    logic [3:0]  drive_next;

    logic                      div_start;
    logic                      div_done;
    logic [dpt_pkg::DIV_W-1:0] div_q;
    logic [dpt_pkg::DIV_W-1:0] product;

    assign out_free = !out_valid_reg || m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dpt_pkg::ST_IDLE:
                if (q_valid && out_free && q_cmd.op == dpt_pkg::OP_VOLUME)
                begin
                    state_next = dpt_pkg::ST_MUL;
                end
            dpt_pkg::ST_MUL:
                state_next = dpt_pkg::ST_DIV;
            dpt_pkg::ST_DIV:
                if (div_done)
                begin
                    state_next = dpt_pkg::ST_LOAD;
                end
            dpt_pkg::ST_LOAD:
                if (out_free)
                begin
                    state_next = dpt_pkg::ST_IDLE;
                end
            default:
                state_next = dpt_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        pop       = 1'b0;
        exec_en   = 1'b0;
        exec_op   = dpt_pkg::OP_NONE;
        exec_id   = q_cmd.pump_id;
        exec_ms   = q_cmd.dose_time_ms;
        capture   = 1'b0;
        div_start = 1'b0;
        unique case (state_reg)
            dpt_pkg::ST_IDLE:
            begin
                pop = q_valid && out_free;
                if (pop)
                begin
                    if (q_cmd.op == dpt_pkg::OP_VOLUME)
                    begin
                        capture = 1'b1;
                    end
                    else
                    begin
                        exec_en = 1'b1;
                        exec_op = q_cmd.op;
                    end
                end
            end
            dpt_pkg::ST_MUL:
                div_start = 1'b1;
            dpt_pkg::ST_DIV:
                div_start = 1'b0;
            dpt_pkg::ST_LOAD:
            begin
                exec_en = out_free;
                exec_op = dpt_pkg::OP_VOLUME;
                exec_id = cur_id_reg;
                exec_ms = loaded_reg;
            end
            default:
                exec_en = 1'b0;
        endcase
    end

    // Flow for the addressed pump; pumps without a register, or with a zero register, use the default.
    always_comb
    begin
        flow_sel = dpt_pkg::DEFAULT_FLOW;
        for (int i = 0; i < dpt_pkg::FLOW_REGS; i++)
        begin
            if (q_cmd.pump_id == 3'(i) && flow_rate[i] != '0)
            begin
                flow_sel = flow_rate[i];
            end
        end
    end

    assign product = dpt_pkg::DIV_W'(cur_vol_reg) * dpt_pkg::DIV_W'(dpt_pkg::MS_PER_S);

    dpt_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (flow_sel_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Saturate to 32 bits, then raise to the minimum dose length.
    always_comb
    begin
        loaded_next = loaded_reg;
        if (div_done)
        begin
            if (div_q[dpt_pkg::DIV_W-1:32] != '0)
            begin
                loaded_next = '1;
            end
            else if (div_q[31:0] < dpt_pkg::MIN_DOSE_MS)
            begin
                loaded_next = dpt_pkg::MIN_DOSE_MS;
            end
            else
            begin
                loaded_next = div_q[31:0];
            end
        end
    end

    // Timer update for the operation being executed.
    always_comb
    begin
        on_next = on_reg;
        for (int i = 0; i < PUMP_COUNT; i++)
        begin
            rem_next[i] = rem_reg[i];
            case (exec_op)
                dpt_pkg::OP_TICK:
                    if (on_reg[i])
                    begin
                        if (rem_reg[i] <= 32'd1)
                        begin
                            on_next[i]  = 1'b0;
                            rem_next[i] = '0;
                        end
                        else
                        begin
                            rem_next[i] = rem_reg[i] - 32'd1;
                        end
                    end
                dpt_pkg::OP_TIME, dpt_pkg::OP_VOLUME:
                    if (exec_id == 3'(i))
                    begin
                        on_next[i]  = 1'b1;
                        rem_next[i] = exec_ms;
                    end
                dpt_pkg::OP_STOP_ONE:
                    if (exec_id == 3'(i))
                    begin
                        on_next[i]  = 1'b0;
                        rem_next[i] = '0;
                    end
                dpt_pkg::OP_STOP_ALL:
                begin
                    on_next[i]  = 1'b0;
                    rem_next[i] = '0;
                end
                default:
                    rem_next[i] = rem_reg[i];
            endcase
        end
        drive_next = '0;
        for (int i = 0; i < dpt_pkg::DRIVE_W; i++)
        begin
            if (i < PUMP_COUNT)
            begin
                drive_next[i] = on_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cur_id_reg   <= q_cmd.pump_id;
            cur_vol_reg  <= q_cmd.dose_volume;
            flow_sel_reg <= flow_sel;
        end
        loaded_reg <= loaded_next;
        if (exec_en)
        begin
            drive_out_reg  <= drive_next;
            acc_out_reg    <= exec_op != dpt_pkg::OP_NONE;
            loaded_out_reg <= (exec_op == dpt_pkg::OP_TIME || exec_op == dpt_pkg::OP_VOLUME)
                              ? exec_ms : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpt_pkg::ST_IDLE;
            on_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PUMP_COUNT; i++)
            begin
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (exec_en)
            begin
                on_reg <= on_next;
                for (int i = 0; i < PUMP_COUNT; i++)
                begin
                    rem_reg[i] <= rem_next[i];
                end
            end
            if (exec_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, loaded_out_reg, acc_out_reg, drive_out_reg};

    logic [PUMP_COUNT-1:0] rem_nonzero;
    always_comb
    begin
        for (int i = 0; i < PUMP_COUNT; i++)
        begin
            rem_nonzero[i] = rem_reg[i] != '0;
        end
    end

    // A stopped pump never keeps a count.
    a_off_has_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_nonzero & ~on_reg) == '0)
        else $error("stopped pump holds a nonzero count");

    // The divider finishes only while the sequencer waits for it.
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == dpt_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    // A converted volume dose is never shorter than the minimum.
    a_min_dose: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == dpt_pkg::ST_LOAD |-> loaded_reg >= dpt_pkg::MIN_DOSE_MS)
        else $error("volume dose below the minimum length");

    // The queue is only drained while the sequencer is idle.
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> $past(state_reg) == dpt_pkg::ST_IDLE)
        else $error("command taken while a volume dose is in progress");

endmodule

`default_nettype wire

### src/dosing_pump_timer_bank.sv
// Top level of the dosing pump timer bank: flow registers, front end, queue, back end.
// Depends on dpt_pkg, dpt_front, dpt_cmd_queue and dpt_back.
//
// Usage. Each request on the s_ channel is one command: tuser carries the kind
// (tick, dose by time, dose by volume, stop one, stop all) and tdata carries the
// pump id, the dose time and the dose volume. Every request yields exactly one
// result on the m_ channel with the drive bits after the command, an accepted
// flag and the duration that a dose loaded. The APB port holds four 16-bit flow
// registers, for pumps 0 to 3; write them only while no request is in flight.
// Throughput: a command enters a two-entry queue, is executed by the back end and
// its result is registered; such commands sustain one per cycle while the receiver
// keeps up and no volume dose is in progress. A volume dose forms volume*1000 in
// the MUL state, goes through the shared bit-serial divider in DIV, and loads the
// timer in LOAD; it holds the back end until then.
// Reset clears every timer, turns all drives off and sets each flow register
// to 256 (1.0 mL/s). When the receiver stalls, the result register holds its
// value, the back end stops taking commands, and s_tready falls once the queue
// has filled with two commands.
`timescale 1ns / 1ps
`default_nettype none

module dosing_pump_timer_bank #(
    parameter int PUMP_COUNT = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Command requests.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata from bit 0: pump_id[2:0], dose_time_ms[34:3], dose_volume[58:35], zero pad.
    input  wire logic [63:0] s_tdata,
    // s_tuser: kind[2:0].
    input  wire logic [2:0]  s_tuser,
    // Result requests.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata from bit 0: pump_drive[3:0], accepted[4], loaded_time_ms[36:5], zero pad.
    output logic [39:0]      m_tdata,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [15:0] flow_reg [dpt_pkg::FLOW_REGS];
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    logic          q_full;
    logic          push;
    logic          pop;
    logic          q_valid;
    dpt_pkg::cmd_t front_cmd;
    dpt_pkg::cmd_t q_cmd;

    // Flow registers sit at byte address 4*i; all four addresses map to a register.
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = {16'd0, flow_reg[cfg_idx]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dpt_pkg::FLOW_REGS; i++)
            begin
                flow_reg[i] <= dpt_pkg::DEFAULT_FLOW;
            end
        end
        else if (cfg_wr)
        begin
            flow_reg[cfg_idx] <= pwdata[15:0];
        end
    end

    // The front end decodes the kind and checks the pump id and volume so that
    // the back end sees every rejected command as OP_NONE.
    dpt_front #(
        .PUMP_COUNT (PUMP_COUNT)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .cmd      (front_cmd)
    );

    // The queue lets requests keep arriving while a volume dose is in the divider
    // or while a result waits for the receiver.
    dpt_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    dpt_back #(
        .PUMP_COUNT (PUMP_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .flow_rate (flow_reg),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for dosing_pump_timer_bank: a directed command table, then
// random command streams across several flow register settings. Depends on dpt_pkg.
`timescale 1ns / 1ps

module tb;

    localparam int PUMPS = 4;
    // Highest value the 3-bit kind field can carry; kinds above stop-all are unused codes.
    localparam logic [2:0] KIND_CODE_MAX = 3'd7;
    localparam logic [2:0] KIND_UNUSED_MIN = dpt_pkg::KIND_STOP_ALL + 3'd1;
    localparam logic [31:0] DOSE_MIN_MS = 32'd100;
    localparam logic [63:0] MS_PER_SECOND = 64'd1000;
    localparam logic [15:0] FLOW_FALLBACK = 16'd256;
    // Extra wait after the last result so that any straggler is covered.
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 200;

    // One command as it travels on the request side.
    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  pump_id;
        logic [31:0] dose_ms;
        logic [23:0] volume;
    } pump_cmd_t;

    // One result as it travels on the result side.
    typedef struct packed {
        logic [3:0]  drive;
        logic        accepted;
        logic [31:0] loaded_ms;
    } pump_result_t;

    // A row of the directed table; when fixed is set the typed-in result is the expectation.
    typedef struct packed {
        pump_cmd_t    cmd;
        logic         fixed;
        pump_result_t want;
    } cmd_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow of the block: flow registers, countdowns and drive flags.
    logic [15:0] flow_reg [PUMPS];
    logic [31:0] ms_left [PUMPS];
    logic        running [PUMPS];

    pump_result_t pending_results [$];
    cmd_row_t     directed_rows [$];
    int           mismatches = 0;
    int           cycles = 0;
    int           hold_left = 0;
    // Set for the closing stretch, where neither side idles.
    logic         calm = 1'b0;

    dosing_pump_timer_bank #(
        .PUMP_COUNT(PUMPS)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Watchdog: a run that hangs anywhere ends here as a failure.
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%t timeout after %0d cycles, %0d results outstanding", $time, cycles,
                     pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver back-pressure: alternating runs of readiness and stalls.
    // The ready runs are sometimes long, which gives stretches with no stalls at all.
    always @(posedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (hold_left != 0)
            hold_left = hold_left - 1;
        else if (m_tready)
        begin
            m_tready <= 1'b0;
            hold_left = $urandom_range(0, 18);
        end
        else
        begin
            m_tready <= 1'b1;
            hold_left = $urandom_range(0, 80);
        end
    end

    // Result checker: every accepted result is matched against the oldest expectation.
    always @(posedge clk)
    begin
        pump_result_t expected;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%t unexpected result: expected none, actual %h", $time, m_tdata);
                mismatches = mismatches + 1;
            end
            else
            begin
                expected = pending_results.pop_front();
                if (m_tdata[3:0] !== expected.drive)
                begin
                    $display("%t pump_drive: expected %h, actual %h", $time, expected.drive,
                             m_tdata[3:0]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[4] !== expected.accepted)
                begin
                    $display("%t accepted: expected %b, actual %b", $time, expected.accepted,
                             m_tdata[4]);
                    mismatches = mismatches + 1;
                end
                if (m_tdata[36:5] !== expected.loaded_ms)
                begin
                    $display("%t loaded_time_ms: expected %h, actual %h", $time,
                             expected.loaded_ms, m_tdata[36:5]);
                    mismatches = mismatches + 1;
                end
            end
        end
    end

    // Applies one command to the shadow state and returns the result the block should give.
    // A tick stops a pump whose count is 0 or 1, so an N ms dose ends on the N-th tick and a 0 ms dose on the first.
    function automatic pump_result_t drive_after_command(input pump_cmd_t c);
        pump_result_t r;
        logic [63:0]  span;
        logic [15:0]  flow;
        int           i;
        r = '0;
        case (c.kind)
            dpt_pkg::KIND_TICK:
            begin
                for (i = 0; i < PUMPS; i++)
                begin
                    if (running[i])
                    begin
                        if (ms_left[i] <= 32'd1)
                        begin
                            running[i] = 1'b0;
                            ms_left[i] = '0;
                        end
                        else
                            ms_left[i] = ms_left[i] - 32'd1;
                    end
                end
                r.accepted = 1'b1;
            end
            dpt_pkg::KIND_DOSE_TIME:
            begin
                if (c.pump_id < PUMPS)
                begin
                    running[c.pump_id] = 1'b1;
                    ms_left[c.pump_id] = c.dose_ms;
                    r.loaded_ms = c.dose_ms;
                    r.accepted = 1'b1;
                end
            end
            dpt_pkg::KIND_DOSE_VOL:
            begin
                if (c.pump_id < PUMPS && c.volume != 24'd0)
                begin
                    // A zero flow register means the default of 1.0 mL/s.
                    flow = (flow_reg[c.pump_id] == 16'd0) ? FLOW_FALLBACK
                                                          : flow_reg[c.pump_id];
                    span = (64'(c.volume) * MS_PER_SECOND) / 64'(flow);
                    if (span > 64'hFFFF_FFFF)
                        span = 64'hFFFF_FFFF;
                    if (span < 64'(DOSE_MIN_MS))
                        span = 64'(DOSE_MIN_MS);
                    running[c.pump_id] = 1'b1;
                    ms_left[c.pump_id] = span[31:0];
                    r.loaded_ms = span[31:0];
                    r.accepted = 1'b1;
                end
            end
            dpt_pkg::KIND_STOP_ONE:
            begin
                if (c.pump_id < PUMPS)
                begin
                    running[c.pump_id] = 1'b0;
                    ms_left[c.pump_id] = '0;
                    r.accepted = 1'b1;
                end
            end
            dpt_pkg::KIND_STOP_ALL:
            begin
                for (i = 0; i < PUMPS; i++)
                begin
                    running[i] = 1'b0;
                    ms_left[i] = '0;
                end
                r.accepted = 1'b1;
            end
            default:
                ;
        endcase
        for (i = 0; i < PUMPS; i++)
            r.drive[i] = running[i];
        return r;
    endfunction

    function automatic void add_row(input logic [2:0] kind, input logic [2:0] id,
                                    input logic [31:0] ms, input logic [23:0] vol,
                                    input logic fixed, input logic [3:0] drive,
                                    input logic acc, input logic [31:0] loaded);
        cmd_row_t row;
        row.cmd = '{kind: kind, pump_id: id, dose_ms: ms, volume: vol};
        row.fixed = fixed;
        row.want = '{drive: drive, accepted: acc, loaded_ms: loaded};
        directed_rows.push_back(row);
    endfunction

    // Random command: mostly ticks and short doses so that pumps run out on their own,
    // with bad ids, zero and extreme volumes, huge times and unused kinds mixed in.
    // Fields that a kind does not use carry random bits as well.
    function automatic pump_cmd_t random_command();
        pump_cmd_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        c.dose_ms = $urandom;
        c.volume = 24'($urandom);
        c.pump_id = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, PUMPS - 1))
                                                : 3'($urandom_range(PUMPS, 7));
        if (pick < 45)
            c.kind = dpt_pkg::KIND_TICK;
        else if (pick < 65)
            c.kind = dpt_pkg::KIND_DOSE_TIME;
        else if (pick < 80)
            c.kind = dpt_pkg::KIND_DOSE_VOL;
        else if (pick < 90)
            c.kind = dpt_pkg::KIND_STOP_ONE;
        else if (pick < 95)
            c.kind = dpt_pkg::KIND_STOP_ALL;
        else
            c.kind = 3'($urandom_range(KIND_UNUSED_MIN, KIND_CODE_MAX));
        if (c.kind == dpt_pkg::KIND_DOSE_TIME)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                c.dose_ms = $urandom_range(0, 6);
            else if (pick < 80)
                c.dose_ms = $urandom_range(7, 300);
        end
        if (c.kind == dpt_pkg::KIND_DOSE_VOL)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                c.volume = 24'($urandom_range(1, 4000));
            else if (pick < 70)
                c.volume = 24'd0;
            else if (pick < 80)
                c.volume = 24'hFF_FFFF;
        end
        return c;
    endfunction

    // Flow setting for one register: extremes often, otherwise a moderate rate.
    function automatic logic [15:0] random_flow();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom_range(1, 4096));
        endcase
    endfunction

    // APB write; psel stays high so that back-to-back writes never lower and raise it
    // within one time step. The caller releases the bus after the last write.
    task automatic write_flow(input int idx, input logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 4'(idx * 4);
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        flow_reg[idx] = value;
    endtask

    task automatic program_flows(input logic [15:0] f0, input logic [15:0] f1,
                                 input logic [15:0] f2, input logic [15:0] f3);
        write_flow(0, f0);
        write_flow(1, f1);
        write_flow(2, f2);
        write_flow(3, f3);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Presents one command and holds it until the block takes it. tvalid is left high
    // so that the next request can follow without a gap.
    task automatic send_command(input pump_cmd_t c, input logic fixed,
                                input pump_result_t want);
        pump_result_t predicted;
        s_tuser <= c.kind;
        s_tdata <= {5'd0, c.volume, c.dose_ms, c.pump_id};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = drive_after_command(c);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // Stops sending and waits until every result is back and the block has gone quiet.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        pump_cmd_t c;
        int        n;
        int        p;
        int        i;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = dpt_pkg::KIND_TICK;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (i = 0; i < PUMPS; i++)
        begin
            flow_reg[i] = FLOW_FALLBACK;
            ms_left[i] = '0;
            running[i] = 1'b0;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Flow extremes for the directed part: pump 0 the slowest possible flow, pump 1
        // zero (falls back to the default), pump 2 the fastest, pump 3 the reset value.
        program_flows(16'd1, 16'd0, 16'hFFFF, FLOW_FALLBACK);

        // Directed table. Rows typed in by hand: reset state, bad ids, zero volume,
        // unused kinds, a 0 ms dose ending on the next tick, saturation and the 100 ms floor.
        add_row(dpt_pkg::KIND_TICK, 3'd0, 32'd0, 24'd0, 1, 4'h0, 1, 32'd0);
        add_row(dpt_pkg::KIND_STOP_ALL, 3'd0, 32'd0, 24'd0, 1, 4'h0, 1, 32'd0);
        add_row(dpt_pkg::KIND_STOP_ONE, 3'd2, 32'd0, 24'd0, 1, 4'h0, 1, 32'd0);
        add_row(dpt_pkg::KIND_STOP_ONE, 3'd5, 32'd0, 24'd0, 1, 4'h0, 0, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_TIME, 3'd0, 32'd0, 24'd0, 1, 4'h1, 1, 32'd0);
        add_row(dpt_pkg::KIND_TICK, 3'd0, 32'd0, 24'd0, 1, 4'h0, 1, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_TIME, 3'd3, 32'hFFFF_FFFF, 24'd0, 1, 4'h8, 1,
                32'hFFFF_FFFF);
        add_row(dpt_pkg::KIND_DOSE_TIME, 3'd4, 32'd5, 24'd0, 1, 4'h8, 0, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_TIME, 3'd7, 32'd5, 24'hFF_FFFF, 1, 4'h8, 0, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_TIME, 3'd1, 32'd2, 24'd0, 1, 4'hA, 1, 32'd2);
        add_row(dpt_pkg::KIND_TICK, 3'd0, 32'd0, 24'd0, 1, 4'hA, 1, 32'd0);
        add_row(dpt_pkg::KIND_TICK, 3'd0, 32'd0, 24'd0, 1, 4'h8, 1, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd1, 32'hFFFF_FFFF, 24'd0, 1, 4'h8, 0, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd0, 32'd0, 24'hFF_FFFF, 1, 4'h9, 1,
                32'hFFFF_FFFF);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd1, 32'd0, 24'd256, 1, 4'hB, 1, 32'd1000);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd2, 32'd0, 24'd1, 1, 4'hF, 1, 32'd100);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd3, 32'd0, 24'hFF_FFFF, 0, 4'h0, 0, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd6, 32'd0, 24'd5, 1, 4'hF, 0, 32'd0);
        add_row(KIND_UNUSED_MIN, 3'd0, 32'd9, 24'd9, 1, 4'hF, 0, 32'd0);
        add_row(KIND_CODE_MAX, 3'd7, 32'hFFFF_FFFF, 24'hFF_FFFF, 1, 4'hF, 0, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_TIME, 3'd2, 32'h5A5A_5A5A, 24'hA5_A5A5, 0, 4'h0, 0,
                32'd0);
        add_row(dpt_pkg::KIND_STOP_ONE, 3'd0, 32'd0, 24'd0, 1, 4'hE, 1, 32'd0);
        add_row(dpt_pkg::KIND_STOP_ALL, 3'd0, 32'd0, 24'd0, 1, 4'h0, 1, 32'd0);
        add_row(dpt_pkg::KIND_DOSE_VOL, 3'd3, 32'd0, 24'h80_0000, 0, 4'h0, 0, 32'd0);
        add_row(dpt_pkg::KIND_TICK, 3'd0, 32'd0, 24'd0, 0, 4'h0, 0, 32'd0);

        foreach (directed_rows[r])
            send_command(directed_rows[r].cmd, directed_rows[r].fixed, directed_rows[r].want);

        // Random phases. Each begins with the bank idle and a new flow setting; the
        // first two use only extremes, the rest mix extremes with moderate rates.
        // The last phase runs with no idling on either side.
        for (p = 0; p < PHASES; p++)
        begin
            drain();
            if (p == 0)
                program_flows(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else if (p == 1)
                program_flows(16'd1, 16'd1, 16'd1, 16'd0);
            else
                program_flows(random_flow(), random_flow(), random_flow(), random_flow());
            if (p == PHASES - 1)
                calm = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Sender gaps come in bursts, except in the first part of every hundred.
                if (!calm && (n % 100) >= 30 && $urandom_range(0, 99) < 12)
                begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 19)) @(posedge clk);
                end
                c = random_command();
                send_command(c, 1'b0, '0);
            end
        end

        drain();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
